>>> rtl/aatpc_pkg.sv
package aatpc_pkg;

    localparam int NumChannels    = 5;
    localparam int SamplesPerMean = 16;
    localparam int SampleBits     = 10;
    localparam int CalChannels    = 5;

    localparam int ChanBits  = 3;
    localparam int CntBits   = $clog2(SamplesPerMean + 1);
    localparam int SumBits   = SampleBits + $clog2(SamplesPerMean + 1);
    localparam int MeanBits  = 10;
    localparam int GainBits  = 34;
    localparam int DivBits   = 32;
    localparam int DivCntBits = 6;

    localparam logic [GainBits-1:0] GainOne = GainBits'(65536);
    localparam logic [15:0] HandledBits = 16'h03FF;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CAL    = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic                sample_go;    // accumulate the latched sample
        logic                zero_go;      // capture zero of cal_idx
        logic                div_start;    // start gain divide of cal_idx
        logic                gain_write;   // store divide result
        logic                cal_clear;    // clear calibration status
        logic                out_load_avg; // load an average result
        logic                out_load_cal; // load a calibration result
        logic [ChanBits-1:0] cal_idx;
    } aatpc_cmd_t;

    // Status back to controller
    typedef struct packed {
        logic block_done;  // sample completed a block
        logic div_busy;
        logic out_full;
    } aatpc_stat_t;

endpackage

>>> rtl/aatpc_ctrl.sv
module aatpc_ctrl
    import aatpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_op,
    input  logic [15:0]         req_mask,
    output logic                req_ready,
    output aatpc_cmd_t          cmd,
    input  aatpc_stat_t         stat
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SAMPLE = 3'd1;
    localparam logic [2:0] S_ZERO   = 3'd2;
    localparam logic [2:0] S_GAIN   = 3'd3;
    localparam logic [2:0] S_WAIT   = 3'd4;
    localparam logic [2:0] S_CDONE  = 3'd5;
    localparam logic [2:0] S_AVG    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [ChanBits-1:0] idx_reg, idx_next;
    logic [15:0]         mask_reg, mask_next;

    // Accept only when idle
    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mask_next  = mask_reg;
        cmd        = '0;
        cmd.cal_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mask_next = req_mask;
                    idx_next  = '0;
                    if (req_op == OP_CAL)
                    begin
                        cmd.cal_clear = 1'b1;
                        state_next = S_ZERO;
                    end
                    else
                    begin
                        state_next = S_SAMPLE;
                    end
                end
            end
            S_SAMPLE:
            begin
                // accumulate; a finished block stores its mean first
                cmd.sample_go = 1'b1;
                if (stat.block_done)
                    state_next = S_AVG;
                else
                    state_next = S_IDLE;
            end
            S_AVG:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load_avg = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ZERO:
            begin
                // one channel per cycle
                if (32'(idx_reg) < NumChannels && mask_reg[{1'b0, idx_reg}])
                    cmd.zero_go = 1'b1;
                if (32'(idx_reg) == CalChannels - 1)
                begin
                    idx_next = '0;
                    state_next = S_GAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_GAIN:
            begin
                if (32'(idx_reg) < NumChannels && mask_reg[4'(idx_reg) + 4'd5])
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_WAIT;
                end
                else if (32'(idx_reg) == CalChannels - 1)
                begin
                    state_next = S_CDONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.gain_write = 1'b1;
                    if (32'(idx_reg) == CalChannels - 1)
                        state_next = S_CDONE;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_GAIN;
                    end
                end
            end
            S_CDONE:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load_cal = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            mask_reg  <= mask_next;
        end
    end

endmodule

>>> rtl/aatpc_datapath.sv
module aatpc_datapath
    import aatpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_take,
    input  logic [ChanBits-1:0]   req_channel,
    input  logic [9:0]            req_sample,
    input  logic [15:0]           req_mask,
    input  logic [15:0]           full_scale,
    input  aatpc_cmd_t            cmd,
    output aatpc_stat_t           stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [47:0]           out_data
);

    logic [SumBits-1:0]  sum_reg  [NumChannels];
    logic [CntBits-1:0]  cnt_reg  [NumChannels];
    logic [MeanBits-1:0] mean_reg [NumChannels];
    logic [MeanBits-1:0] zero_reg [NumChannels];
    logic [GainBits-1:0] gain_reg [NumChannels];

    logic [ChanBits-1:0] ch_reg;
    logic [SampleBits-1:0] smp_reg;
    logic                ch_ok;
    logic [15:0]         mask_reg;
    logic                status_reg;

    logic [SumBits-1:0]  new_sum;
    logic [CntBits-1:0]  new_cnt;
    logic [MeanBits-1:0] new_mean;

    // Latch request payload
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            ch_reg   <= req_channel;
            smp_reg  <= req_sample[SampleBits-1:0];
            mask_reg <= req_mask;
        end
    end

    assign ch_ok   = (32'(ch_reg) < NumChannels);
    assign new_sum = sum_reg[ch_reg[ChanBits-1:0]] + SumBits'(smp_reg);
    assign new_cnt = cnt_reg[ch_reg] + 1'b1;
    assign new_mean = MeanBits'(new_sum / SamplesPerMean);
    assign stat.block_done = ch_ok && (32'(new_cnt) >= SamplesPerMean);

    // Signed mean-minus-zero for the reported channel, from the stored mean
    logic signed [MeanBits:0]     diff;
    logic signed [MeanBits+GainBits:0] prod;
    logic signed [MeanBits+GainBits:0] prod_adj;
    logic signed [MeanBits+GainBits-16:0] q;
    logic signed [15:0]           scaled;

    assign diff = $signed({1'b0, mean_reg[ch_reg]}) - $signed({1'b0, zero_reg[ch_reg]});
    assign prod = diff * $signed(gain_reg[ch_reg]);
    // bias negative products so the shift truncates toward zero
    assign prod_adj = prod + $signed({{(MeanBits+GainBits-15){1'b0}},
                                      {16{prod[MeanBits+GainBits]}}});
    always_comb
    begin
        q = prod_adj[MeanBits+GainBits:16];
        if (q > 32767)
            scaled = 16'sd32767;
        else if (q < -32768)
            scaled = -16'sd32768;
        else
            scaled = q[15:0];
    end

    // Restoring divider: |fs*65536| / |span|
    logic [DivBits-1:0]  dq_reg;
    logic [MeanBits:0]   drem_reg;
    logic [MeanBits:0]   dden_reg;
    logic                dneg_reg;
    logic [DivCntBits-1:0] dcnt_reg;
    logic                dbusy_reg;
    logic                dzero_reg;
    logic signed [MeanBits:0] span;
    logic [MeanBits+1:0] trial;

    assign span  = $signed({1'b0, mean_reg[cmd.cal_idx]})
                 - $signed({1'b0, zero_reg[cmd.cal_idx]});
    assign trial = {drem_reg, dq_reg[DivBits-1]} - {1'b0, dden_reg};
    assign stat.div_busy = dbusy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            dbusy_reg <= (span != 0);
        end
        else if (dbusy_reg && dcnt_reg == DivCntBits'(DivBits - 1))
        begin
            dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dq_reg    <= {full_scale, 16'd0};
            drem_reg  <= '0;
            dden_reg  <= span[MeanBits] ? MeanBits'(0) - span : span;
            dneg_reg  <= span[MeanBits];
            dzero_reg <= (span == 0);
            dcnt_reg  <= '0;
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
            if (!trial[MeanBits+1])
            begin
                drem_reg <= trial[MeanBits:0];
                dq_reg   <= {dq_reg[DivBits-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[MeanBits-1:0], dq_reg[DivBits-1]};
                dq_reg   <= {dq_reg[DivBits-2:0], 1'b0};
            end
        end
    end

    // Per-channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumChannels; i++)
            begin
                sum_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                mean_reg[i] <= '0;
                zero_reg[i] <= '0;
                gain_reg[i] <= GainOne;
            end
            status_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sample_go && ch_ok)
            begin
                if (stat.block_done)
                begin
                    sum_reg[ch_reg]  <= '0;
                    cnt_reg[ch_reg]  <= '0;
                    mean_reg[ch_reg] <= new_mean;
                end
                else
                begin
                    sum_reg[ch_reg] <= new_sum;
                    cnt_reg[ch_reg] <= new_cnt;
                end
            end
            if (cmd.cal_clear)
                status_reg <= 1'b0;
            if (cmd.zero_go)
                zero_reg[cmd.cal_idx] <= mean_reg[cmd.cal_idx];
            if (cmd.gain_write)
            begin
                if (dzero_reg)
                begin
                    gain_reg[cmd.cal_idx] <= '0;
                    status_reg <= 1'b1;
                end
                else if (dneg_reg)
                    gain_reg[cmd.cal_idx] <= GainBits'(0) - GainBits'(dq_reg);
                else
                    gain_reg[cmd.cal_idx] <= GainBits'(dq_reg);
            end
        end
    end

    // Output register
    logic        ovalid_reg;
    logic [47:0] odata_reg;
    assign stat.out_full = ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.out_load_avg || cmd.out_load_cal)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    // out fields: kind, out_channel, mean_value, scaled_value, remaining_flags, status
    always_ff @(posedge clk)
    begin
        if (cmd.out_load_avg)
            odata_reg <= {1'b0, 1'b0, 16'd0, scaled, mean_reg[ch_reg], ch_reg, 1'b0};
        else if (cmd.out_load_cal)
            odata_reg <= {1'b0, status_reg || (cmd.gain_write && dzero_reg),
                          mask_reg & ~HandledBits, 16'd0, 10'd0, 3'd0, 1'b1};
    end

endmodule

>>> rtl/adc_average_two_point_calibration_core.sv
// Channel     | Dir | Handshake       | Payload
// s_axis      | in  | tvalid/tready   | tdata: operation, channel, sample_value, cal_mask
// m_axis      | out | tvalid/tready   | tdata: kind, out_channel, mean_value, scaled_value,
//             |     |                 |        remaining_flags, status
// apb         | in  | psel/penable    | full_scale_target at address 0
// A sample is accepted, then accumulated; one that closes a block also stores the mean
// in that step, then loads the scaled result.
// A calibration captures the zeros, then runs the bit-serial divider for each masked
// gain with a nonzero span and stores the gains, then loads the result.
// rst_n asynchronously clears sums, counts, means and zeros; gains reset to 1.0.
// A full output register stalls the controller until the result is taken.
module adc_average_two_point_calibration_core
    import aatpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // operation, channel[3], sample_value[10], cal_mask[16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // kind, out_channel[3], mean_value[10],
                                       // scaled_value[16], remaining_flags[16], status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    aatpc_cmd_t  cmd;
    aatpc_stat_t stat;
    logic [15:0] fs_reg;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, fs_reg} : 32'd0;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fs_reg <= '0;
        else if (psel && penable && pwrite && paddr == 1'b0)
            fs_reg <= pwdata[15:0];
    end

    aatpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_axis_tvalid),
        .req_op    (s_axis_tdata[0]),
        .req_mask  (s_axis_tdata[29:14]),
        .req_ready (s_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    aatpc_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_take    (s_axis_tvalid && s_axis_tready),
        .req_channel (s_axis_tdata[3:1]),
        .req_sample  (s_axis_tdata[13:4]),
        .req_mask    (s_axis_tdata[29:14]),
        .full_scale  (fs_reg),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata)
    );

endmodule
